[hw/rtl/tbr_pkg.sv]
// Shared constants, types and arctangent table for the bearing and range core.
`default_nettype none

package tbr_pkg;

   localparam int COORD_WIDTH   = 16;
   localparam int CORDIC_STEPS  = 16;
   localparam int ATAN_LEN      = 24;
   localparam int STAGES        = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
   localparam int FRAC_BITS     = 8;
   localparam int DIFF_WIDTH    = COORD_WIDTH + 1;
   localparam int XY_WIDTH      = DIFF_WIDTH + FRAC_BITS + 3;
   localparam int Z_WIDTH       = 34;
   localparam int ZC_WIDTH      = 33;
   localparam int K_WIDTH       = 32;
   localparam int AP_WIDTH      = ZC_WIDTH + K_WIDTH + 1;
   localparam int RP_NATURAL    = XY_WIDTH - 1 + K_WIDTH;
   localparam int RP_MIN        = 38 + 17 + 1;
   localparam int RP_WIDTH      = (RP_NATURAL > RP_MIN) ? RP_NATURAL : RP_MIN;
   localparam int BEARING_WIDTH = 16;
   localparam int RANGE_WIDTH   = 17;
   localparam int LATENCY       = STAGES + 3;

   localparam logic signed [Z_WIDTH-1:0] HALF_TURN =
      $signed({{(Z_WIDTH-32){1'b0}}, 1'b1, 31'b0});
   localparam logic [K_WIDTH-1:0] KGAIN_Q30 = 32'd652032874;
   localparam logic [K_WIDTH-1:0] PI_Q29    = 32'd1686629713;
   localparam logic [K_WIDTH-1:0] DEG_SCALE = 32'd46080;
   localparam logic [RANGE_WIDTH-1:0] RANGE_MAX = {RANGE_WIDTH{1'b1}};

   typedef struct packed {
      logic signed [XY_WIDTH-1:0] x;
      logic signed [XY_WIDTH-1:0] y;
      logic signed [Z_WIDTH-1:0]  z;
      logic                       unit;
      logic                       zero;
   } tbr_vec_type;

   // round(atan(2^-i) * 2^32 / (2*pi))
   function automatic logic [31:0] tbr_atan(input logic [4:0] idx);
      logic [31:0] val;
      case (idx)
         5'd0:    val = 32'd536870912;
         5'd1:    val = 32'd316933406;
         5'd2:    val = 32'd167458907;
         5'd3:    val = 32'd85004756;
         5'd4:    val = 32'd42667331;
         5'd5:    val = 32'd21354465;
         5'd6:    val = 32'd10679838;
         5'd7:    val = 32'd5340245;
         5'd8:    val = 32'd2670163;
         5'd9:    val = 32'd1335087;
         5'd10:   val = 32'd667544;
         5'd11:   val = 32'd333772;
         5'd12:   val = 32'd166886;
         5'd13:   val = 32'd83443;
         5'd14:   val = 32'd41722;
         5'd15:   val = 32'd20861;
         5'd16:   val = 32'd10430;
         5'd17:   val = 32'd5215;
         5'd18:   val = 32'd2608;
         5'd19:   val = 32'd1304;
         5'd20:   val = 32'd652;
         5'd21:   val = 32'd326;
         5'd22:   val = 32'd163;
         5'd23:   val = 32'd81;
         default: val = 32'd0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/tbr_prep.sv]
// Difference, half-turn fold and accumulator seed ahead of the CORDIC stages.
`default_nettype none

module tbr_prep import tbr_pkg::*; (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          src_valid,
   input  wire logic signed [COORD_WIDTH-1:0] goal_x,
   input  wire logic signed [COORD_WIDTH-1:0] goal_y,
   input  wire logic signed [COORD_WIDTH-1:0] here_x,
   input  wire logic signed [COORD_WIDTH-1:0] here_y,
   input  wire logic                          unit,
   output logic                               dst_valid,
   output tbr_vec_type                        dst_vec
);

   logic signed [DIFF_WIDTH-1:0] dx;
   logic signed [DIFF_WIDTH-1:0] dy;
   logic signed [XY_WIDTH-1:0]   xs;
   logic signed [XY_WIDTH-1:0]   ys;
   tbr_vec_type                  vec_in;
   tbr_vec_type                  vec_ff;
   logic                         valid_ff;

   always_comb begin
      dx = $signed({goal_x[COORD_WIDTH-1], goal_x}) - $signed({here_x[COORD_WIDTH-1], here_x});
      dy = $signed({goal_y[COORD_WIDTH-1], goal_y}) - $signed({here_y[COORD_WIDTH-1], here_y});
      xs = $signed({{(XY_WIDTH-DIFF_WIDTH-FRAC_BITS){dx[DIFF_WIDTH-1]}}, dx,
                    {FRAC_BITS{1'b0}}});
      ys = $signed({{(XY_WIDTH-DIFF_WIDTH-FRAC_BITS){dy[DIFF_WIDTH-1]}}, dy,
                    {FRAC_BITS{1'b0}}});
      vec_in.unit = unit;
      vec_in.zero = (dx == '0) && (dy == '0);
      if (dx[DIFF_WIDTH-1]) begin
         vec_in.x = -xs;
         vec_in.y = -ys;
         vec_in.z = dy[DIFF_WIDTH-1] ? -HALF_TURN : HALF_TURN;
      end else begin
         vec_in.x = xs;
         vec_in.y = ys;
         vec_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= src_valid;
      end
      vec_ff <= vec_in;
   end

   assign dst_valid = valid_ff;
   assign dst_vec   = vec_ff;

   ap_x_folded: assert property (@(posedge clock) disable iff (reset)
      dst_valid |-> !dst_vec.x[XY_WIDTH-1])
      else $error("folded x is negative");

endmodule

`default_nettype wire

[hw/rtl/tbr_cordic.sv]
// Unrolled CORDIC vectoring pipeline, one registered micro-rotation per stage.
`default_nettype none

module tbr_cordic import tbr_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  src_valid,
   input  tbr_vec_type src_vec,
   output logic        dst_valid,
   output tbr_vec_type dst_vec
);

   tbr_vec_type pipe_vec   [STAGES+1];
   logic        pipe_valid [STAGES+1];
   tbr_vec_type vec_ff     [STAGES];
   logic        valid_ff   [STAGES];

   assign pipe_vec[0]   = src_vec;
   assign pipe_valid[0] = src_valid;

   for (genvar g = 0; g < STAGES; g++) begin : g_stage
      logic signed [XY_WIDTH-1:0] tx;
      logic signed [XY_WIDTH-1:0] ty;
      logic signed [Z_WIDTH-1:0]  step_angle;
      tbr_vec_type                step_in;

      always_comb begin
         tx         = pipe_vec[g].x >>> g;
         ty         = pipe_vec[g].y >>> g;
         step_angle = $signed({{(Z_WIDTH-32){1'b0}}, tbr_atan(5'(g))});
         step_in    = pipe_vec[g];
         if (!pipe_vec[g].y[XY_WIDTH-1]) begin
            step_in.x = pipe_vec[g].x + ty;
            step_in.y = pipe_vec[g].y - tx;
            step_in.z = pipe_vec[g].z + step_angle;
         end else begin
            step_in.x = pipe_vec[g].x - ty;
            step_in.y = pipe_vec[g].y + tx;
            step_in.z = pipe_vec[g].z - step_angle;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else begin
            valid_ff[g] <= pipe_valid[g];
         end
         vec_ff[g] <= step_in;
      end

      assign pipe_vec[g+1]   = vec_ff[g];
      assign pipe_valid[g+1] = valid_ff[g];
   end

   assign dst_valid = pipe_valid[STAGES];
   assign dst_vec   = pipe_vec[STAGES];

   ap_x_positive: assert property (@(posedge clock) disable iff (reset)
      dst_valid |-> !dst_vec.x[XY_WIDTH-1])
      else $error("CORDIC x went negative");

endmodule

`default_nettype wire

[hw/rtl/tbr_scale.sv]
// Angle clamp, unit scaling, gain correction, rounding and the response register.
`default_nettype none

module tbr_scale import tbr_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  src_valid,
   input  tbr_vec_type src_vec,
   output logic                            rsp_valid,
   output logic signed [BEARING_WIDTH-1:0] rsp_bearing,
   output logic        [RANGE_WIDTH-1:0]   rsp_range
);

   localparam logic signed [Z_WIDTH-1:0] NEG_HALF_TURN = -HALF_TURN;
   localparam logic [AP_WIDTH-1:0] DEG_ROUND = AP_WIDTH'(1) << 31;
   localparam logic [AP_WIDTH-1:0] RAD_ROUND = AP_WIDTH'(1) << 46;
   localparam logic [RP_WIDTH-1:0] RNG_ROUND = RP_WIDTH'(1) << 37;

   // multiply stage
   logic signed [Z_WIDTH-1:0]  z_sel;
   logic signed [ZC_WIDTH-1:0] zc;
   logic        [K_WIDTH-1:0]  angle_k;
   logic        [XY_WIDTH-2:0] x_mag;
   logic signed [AP_WIDTH-1:0] angle_prod_in;
   logic        [RP_WIDTH-1:0] range_prod_in;
   logic signed [AP_WIDTH-1:0] angle_prod_ff;
   logic        [RP_WIDTH-1:0] range_prod_ff;
   logic                       unit_ff;
   logic                       zero_ff;
   logic                       mul_valid_ff;

   // round stage
   logic [AP_WIDTH-1:0]            angle_sum;
   logic [RP_WIDTH-1:0]            range_sum;
   logic [RP_WIDTH-39:0]           range_total;
   logic signed [BEARING_WIDTH-1:0] bearing_in;
   logic [RANGE_WIDTH-1:0]         range_in;
   logic signed [BEARING_WIDTH-1:0] bearing_ff;
   logic [RANGE_WIDTH-1:0]         range_ff;
   logic                           out_valid_ff;

   always_comb begin
      if (src_vec.z > HALF_TURN) begin
         z_sel = HALF_TURN;
      end else if (src_vec.z < NEG_HALF_TURN) begin
         z_sel = NEG_HALF_TURN;
      end else begin
         z_sel = src_vec.z;
      end
      zc            = ZC_WIDTH'(z_sel);
      angle_k       = src_vec.unit ? PI_Q29 : DEG_SCALE;
      angle_prod_in = zc * $signed({1'b0, angle_k});
      x_mag         = src_vec.x[XY_WIDTH-1] ? '0 : src_vec.x[XY_WIDTH-2:0];
      range_prod_in = RP_WIDTH'(x_mag) * RP_WIDTH'(KGAIN_Q30);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= src_valid;
      end
      angle_prod_ff <= angle_prod_in;
      range_prod_ff <= range_prod_in;
      unit_ff       <= src_vec.unit;
      zero_ff       <= src_vec.zero;
   end

   always_comb begin
      if (unit_ff) begin
         angle_sum  = angle_prod_ff + RAD_ROUND;
         bearing_in = $signed(angle_sum[47 +: BEARING_WIDTH]);
      end else begin
         angle_sum  = angle_prod_ff + DEG_ROUND;
         bearing_in = $signed(angle_sum[32 +: BEARING_WIDTH]);
      end
      range_sum   = range_prod_ff + RNG_ROUND;
      range_total = range_sum[RP_WIDTH-1:38];
      if (range_total > (RP_WIDTH-38)'(RANGE_MAX)) begin
         range_in = RANGE_MAX;
      end else begin
         range_in = RANGE_WIDTH'(range_total);
      end
      if (zero_ff) begin
         bearing_in = '0;
         range_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= mul_valid_ff;
      end
      bearing_ff <= bearing_in;
      range_ff   <= range_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_bearing = bearing_ff;
   assign rsp_range   = range_ff;

   ap_bearing_span: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_bearing <= 16'sd25736 && rsp_bearing >= -16'sd25736))
      else $error("bearing outside half turn");

endmodule

`default_nettype wire

[hw/rtl/target_bearing_and_range_core.sv]
// Top level: bearing and range from target and current positions.
//
// Request channel: start with req_goal_x, req_goal_y, req_here_x, req_here_y
// (signed). A request is taken at every rising edge with start high and busy
// low; busy stays low, so a request may be issued in every cycle.
// Response channel: rsp_valid is high for one cycle with rsp_bearing (signed,
// Q8.7 degrees or Q2.13 radians) and rsp_range (unsigned, whole units).
// Responses come in request order and the receiver has no way to hold them.
// Pipeline: one difference stage, one stage per CORDIC micro-rotation,
// a multiply stage and a rounding stage, each ending in a register.
// Throughput: one request per cycle, set by the fully unrolled CORDIC chain.
// Configuration: csr_write with csr_wdata sets the angle unit (0 degrees,
// 1 radians); write it only while no request is in flight.
// Reset: synchronous, clears the angle unit to degrees and drops every
// request in flight; no response follows a request taken during reset.
`default_nettype none

module target_bearing_and_range_core import tbr_pkg::*; (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic signed [COORD_WIDTH-1:0]   req_goal_x,
   input  wire logic signed [COORD_WIDTH-1:0]   req_goal_y,
   input  wire logic signed [COORD_WIDTH-1:0]   req_here_x,
   input  wire logic signed [COORD_WIDTH-1:0]   req_here_y,
   output logic                                 rsp_valid,
   output logic signed [BEARING_WIDTH-1:0]      rsp_bearing,
   output logic        [RANGE_WIDTH-1:0]        rsp_range,
   input  wire logic                            csr_write,
   input  wire logic                            csr_wdata
);

   logic        unit_ff;
   logic        prep_valid;
   tbr_vec_type prep_vec;
   logic        rot_valid;
   tbr_vec_type rot_vec;

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ff <= 1'b0;
      end else if (csr_write) begin
         unit_ff <= csr_wdata;
      end
   end

   assign busy = 1'b0;

   tbr_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .src_valid (start & ~busy),
      .goal_x    (req_goal_x),
      .goal_y    (req_goal_y),
      .here_x    (req_here_x),
      .here_y    (req_here_y),
      .unit      (unit_ff),
      .dst_valid (prep_valid),
      .dst_vec   (prep_vec)
   );

   tbr_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .src_valid (prep_valid),
      .src_vec   (prep_vec),
      .dst_valid (rot_valid),
      .dst_vec   (rot_vec)
   );

   tbr_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .src_valid   (rot_valid),
      .src_vec     (rot_vec),
      .rsp_valid   (rsp_valid),
      .rsp_bearing (rsp_bearing),
      .rsp_range   (rsp_range)
   );

   ap_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !reset, LATENCY))
      else $error("response without matching request");

   ap_zero_range_zero_bearing: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_range == '0 && $past(req_goal_x == req_here_x &&
         req_goal_y == req_here_y, LATENCY)) |-> rsp_bearing == '0)
      else $error("equal positions gave nonzero bearing");

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the bearing and range core: directed and random requests.
`timescale 1ns / 100ps
`default_nettype none

module tb;

   localparam int CW = tbr_pkg::COORD_WIDTH;
   localparam int BW = tbr_pkg::BEARING_WIDTH;
   localparam int RW = tbr_pkg::RANGE_WIDTH;
   localparam int PIPE_DEPTH = tbr_pkg::LATENCY;

   localparam logic UNIT_DEGREES = 1'b0;
   localparam logic UNIT_RADIANS = 1'b1;

   localparam longint HALF_CIRCLE = 64'sd2147483648;
   localparam longint GAIN_Q30 = 64'sd652032874;
   localparam longint PI_Q29_TB = 64'sd1686629713;
   localparam longint DEG_PER_TURN = 64'sd46080;
   localparam longint DIST_LIMIT = 64'sd131071;

   localparam longint ARCTAN_BAM [0:23] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81
   };

   typedef struct {
      logic signed [CW-1:0] gx;
      logic signed [CW-1:0] gy;
      logic signed [CW-1:0] hx;
      logic signed [CW-1:0] hy;
      logic                 unit;
      logic signed [BW-1:0] bearing;
      logic [RW-1:0]        range_val;
   } fix_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic signed [CW-1:0] req_goal_x = '0;
   logic signed [CW-1:0] req_goal_y = '0;
   logic signed [CW-1:0] req_here_x = '0;
   logic signed [CW-1:0] req_here_y = '0;
   logic                 rsp_valid;
   logic signed [BW-1:0] rsp_bearing;
   logic [RW-1:0]        rsp_range;
   logic                 csr_write = 1'b0;
   logic                 csr_wdata = 1'b0;

   fix_type pending_fixes[$];
   logic    unit_setting = UNIT_DEGREES;
   int      mismatch_count = 0;

   target_bearing_and_range_core uut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_goal_x  (req_goal_x),
      .req_goal_y  (req_goal_y),
      .req_here_x  (req_here_x),
      .req_here_y  (req_here_y),
      .rsp_valid   (rsp_valid),
      .rsp_bearing (rsp_bearing),
      .rsp_range   (rsp_range),
      .csr_write   (csr_write),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic fix_type predict_fix(input logic signed [CW-1:0] gx, gy, hx, hy,
                                           input logic unit);
      fix_type f;
      longint  dx, dy, x, y, z, tx, ty, b, r;
      f.gx = gx;
      f.gy = gy;
      f.hx = hx;
      f.hy = hy;
      f.unit = unit;
      dx = longint'(gx) - longint'(hx);
      dy = longint'(gy) - longint'(hy);
      if (dx == 0 && dy == 0) begin
         f.bearing = '0;
         f.range_val = '0;
         return f;
      end
      x = dx * 256;
      y = dy * 256;
      z = 0;
      if (dx < 0) begin
         x = -x;
         y = -y;
         z = (dy >= 0) ? HALF_CIRCLE : -HALF_CIRCLE;
      end
      for (int i = 0; i < tbr_pkg::STAGES; i++) begin
         tx = x >>> i;
         ty = y >>> i;
         if (y >= 0) begin
            x = x + ty;
            y = y - tx;
            z = z + ARCTAN_BAM[i];
         end else begin
            x = x - ty;
            y = y + tx;
            z = z - ARCTAN_BAM[i];
         end
      end
      if (z > HALF_CIRCLE) z = HALF_CIRCLE;
      if (z < -HALF_CIRCLE) z = -HALF_CIRCLE;
      if (unit == UNIT_RADIANS)
         b = (z * PI_Q29_TB + (64'sd1 <<< 46)) >>> 47;
      else
         b = (z * DEG_PER_TURN + (64'sd1 <<< 31)) >>> 32;
      if (x < 0) x = 0;
      r = (x * GAIN_Q30 + (64'sd1 <<< 37)) >>> 38;
      if (r > DIST_LIMIT) r = DIST_LIMIT;
      f.bearing = b[BW-1:0];
      f.range_val = r[RW-1:0];
      return f;
   endfunction

   task automatic report_mismatch(input string what);
      $display("tb: mismatch at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      fix_type f;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_fixes.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            f = pending_fixes.pop_front();
            if (rsp_bearing !== f.bearing)
               report_mismatch($sformatf(
                  "bearing %0d, want %0d (goal %0d,%0d here %0d,%0d unit %0b)",
                  rsp_bearing, f.bearing, f.gx, f.gy, f.hx, f.hy, f.unit));
            if (rsp_range !== f.range_val)
               report_mismatch($sformatf(
                  "range %0d, want %0d (goal %0d,%0d here %0d,%0d unit %0b)",
                  rsp_range, f.range_val, f.gx, f.gy, f.hx, f.hy, f.unit));
         end
      end
   end

   task automatic send_fix(input logic signed [CW-1:0] gx, gy, hx, hy);
      @(negedge clock);
      start <= 1'b1;
      req_goal_x <= gx;
      req_goal_y <= gy;
      req_here_x <= hx;
      req_here_y <= hy;
      do @(posedge clock); while (busy !== 1'b0);
      pending_fixes.push_back(predict_fix(gx, gy, hx, hy, unit_setting));
   endtask

   task automatic idle_gap(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start <= 1'b0;
         req_goal_x <= CW'($urandom);
         req_here_y <= CW'($urandom);
      end
   endtask

   task automatic drain_fixes();
      @(negedge clock);
      start <= 1'b0;
      while (pending_fixes.size() != 0) @(posedge clock);
   endtask

   task automatic set_angle_unit(input logic unit);
      drain_fixes();
      repeat (PIPE_DEPTH + 2) @(negedge clock);
      csr_write <= 1'b1;
      csr_wdata <= unit;
      @(negedge clock);
      csr_write <= 1'b0;
      csr_wdata <= ~unit;
      unit_setting = unit;
   endtask

   function automatic logic signed [CW-1:0] edge_coord();
      case ($urandom_range(0, 5))
         0: return 16'sh8000;
         1: return 16'sh8001;
         2: return -16'sd1;
         3: return 16'sd0;
         4: return 16'sd1;
         default: return 16'sh7FFF;
      endcase
   endfunction

   task automatic send_random_fix();
      logic signed [CW-1:0] gx, gy, hx, hy;
      int kind;
      kind = $urandom_range(0, 9);
      gx = CW'($urandom);
      gy = CW'($urandom);
      hx = CW'($urandom);
      hy = CW'($urandom);
      case (kind)
         4, 5: begin
            // short vector: most of the work happens in the low bits
            hx = CW'(int'($urandom_range(0, 64000)) - 32000);
            hy = CW'(int'($urandom_range(0, 64000)) - 32000);
            gx = CW'(int'(hx) + int'($urandom_range(0, 512)) - 256);
            gy = CW'(int'(hy) + int'($urandom_range(0, 512)) - 256);
         end
         6: begin
            if ($urandom_range(0, 1)) gx = hx;
            else gy = hy;
         end
         7: begin
            gx = hx;
            gy = hy;
         end
         8: begin
            gx = edge_coord();
            gy = edge_coord();
            hx = edge_coord();
            hy = edge_coord();
         end
         default: ;
      endcase
      send_fix(gx, gy, hx, hy);
   endtask

   task automatic test_corner_vectors();
      send_fix(16'sd0, 16'sd0, 16'sd0, 16'sd0);
      send_fix(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
      send_fix(16'sh7FFF, 16'sd0, 16'sh8000, 16'sd0);
      send_fix(16'sh8000, 16'sd0, 16'sh7FFF, 16'sd0);
      send_fix(16'sd0, 16'sh7FFF, 16'sd0, 16'sh8000);
      send_fix(16'sd0, 16'sh8000, 16'sd0, 16'sh7FFF);
      send_fix(16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000);
      send_fix(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
      send_fix(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
      send_fix(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF);
      idle_gap(3);
      send_fix(16'sd1, 16'sd0, 16'sd0, 16'sd0);
      send_fix(-16'sd1, 16'sd0, 16'sd0, 16'sd0);
      send_fix(16'sd0, -16'sd1, 16'sd0, 16'sd0);
   endtask

   task automatic test_random_traffic(input int count, input bit pause_midway);
      int sent, burst;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 32);
         for (int k = 0; k < burst && sent < count; k++) begin
            send_random_fix();
            sent++;
            if (pause_midway && sent == count / 2)
               drain_fixes();
         end
         idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
      end
   endtask

   task automatic test_full_rate(input int count);
      repeat (count) send_random_fix();
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      test_corner_vectors();
      set_angle_unit(UNIT_RADIANS);
      test_corner_vectors();
      test_random_traffic(600, 1'b0);
      set_angle_unit(UNIT_DEGREES);
      test_random_traffic(600, 1'b1);
      test_full_rate(200);
      set_angle_unit(UNIT_RADIANS);
      test_full_rate(100);
      test_random_traffic(200, 1'b0);
      drain_fixes();
      repeat (PIPE_DEPTH + 5) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #20000000;
      $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire

[filelist.f]
hw/rtl/tbr_pkg.sv
hw/rtl/tbr_prep.sv
hw/rtl/tbr_cordic.sv
hw/rtl/tbr_scale.sv
hw/rtl/target_bearing_and_range_core.sv
tb/tb.sv
